// ===== src/bamm_pkg.sv =====
// bamm_pkg: field widths, thresholds and register indexes of the battery level filter
// no dependencies; used by the interfaces, the top level and the checker

package bamm_pkg;

   // field widths
   localparam int SAMPLE_W = 10;
   localparam int PCT_W    = 7;

   // shared divider: dividend covers 1023 * 100, divisor covers a 10-bit level span
   localparam int DIV_W  = 17;
   localparam int DEN_W  = 10;
   localparam int DCNT_W = $clog2(DIV_W + 1);

   // sample window limits (exclusive)
   localparam logic [SAMPLE_W-1:0] LOW_REJECT  = 10'd100;
   localparam logic [SAMPLE_W-1:0] HIGH_REJECT = 10'd1000;

   // full scale of the percentage
   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   // configuration registers
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_EMPTY_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_LEVEL  = 2'd1;

   localparam logic [SAMPLE_W-1:0] EMPTY_LEVEL_RST = 10'd475;
   localparam logic [SAMPLE_W-1:0] FULL_LEVEL_RST  = 10'd665;

endpackage

// ===== src/bamm_ifs.sv =====
// bamm_req_if, bamm_rsp_if, bamm_csr_if: valid/ready channels of the battery level filter
// depends on bamm_pkg for field widths

// raw sample words
interface bamm_req_if;
   logic                          valid;
   logic                          ready;
   logic [bamm_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// filtered result words
interface bamm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic [bamm_pkg::SAMPLE_W-1:0] filtered_level;
   logic [bamm_pkg::PCT_W-1:0]    percent;
   logic                          stable;

   modport source (output valid, output accepted, output filtered_level,
                   output percent, output stable, input ready);
   modport sink   (input valid, input accepted, input filtered_level,
                   input percent, input stable, output ready);
endinterface

// register write words
interface bamm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bamm_pkg::CSR_IDX_W-1:0] index;
   logic [bamm_pkg::SAMPLE_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/battery_adc_median_mean_percent.sv =====
// battery_adc_median_mean_percent: median-then-mean battery level filter with charge percent
// depends on bamm_pkg and the channel interfaces in bamm_ifs.sv

// Takes one 10-bit converter word at a time and returns one result word for it. A rejected
// sample (outside 101..999) skips the median, mean and percent steps and repeats the held
// level, percent and stable flag. An accepted sample first goes through the median scan,
// which tries 1 to MEDIAN_WINDOW candidates, one per cycle, each against every filled
// window entry in parallel. Most of the time goes into one shared 17-step restoring
// divider, used once for the mean (sum by fill count) and once more for the percentage
// unless that is settled as zero. The input is not ready until the word in flight has
// moved to the output register; the output register lets the next word in while a result
// waits. Register writes are taken in any cycle and should be issued while idle.

module battery_adc_median_mean_percent #(
   parameter int MEDIAN_WINDOW = 7,
   parameter int MEAN_WINDOW   = 7
) (
   input  logic       clock,
   input  logic       reset,
   bamm_req_if.sink   req_ch,
   bamm_rsp_if.source rsp_ch,
   bamm_csr_if.sink   csr_ch
);

   localparam int SW     = bamm_pkg::SAMPLE_W;
   localparam int MIDX_W = (MEDIAN_WINDOW > 1) ? $clog2(MEDIAN_WINDOW) : 1;
   localparam int MCNT_W = $clog2(MEDIAN_WINDOW + 1);
   localparam int NIDX_W = (MEAN_WINDOW > 1) ? $clog2(MEAN_WINDOW) : 1;
   localparam int NCNT_W = $clog2(MEAN_WINDOW + 1);
   localparam int SUM_W  = SW + NCNT_W;

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MED      = 3'd1;
   localparam logic [2:0] ST_SUM      = 3'd2;
   localparam logic [2:0] ST_DIV_MEAN = 3'd3;
   localparam logic [2:0] ST_PCT      = 3'd4;
   localparam logic [2:0] ST_DIV_PCT  = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   logic [2:0] state_ff, state_in;

   // windows
   logic [SW-1:0] median_win_ff [MEDIAN_WINDOW];
   logic [SW-1:0] mean_win_ff   [MEAN_WINDOW];
   logic          med_we, mean_we;

   logic [MIDX_W-1:0] med_pos_ff, med_pos_in;
   logic [MCNT_W-1:0] med_fill_ff, med_fill_in;
   logic [MIDX_W-1:0] med_idx_ff, med_idx_in;
   logic [SW-1:0]     med_val_ff, med_val_in;
   logic [NIDX_W-1:0] mean_pos_ff, mean_pos_in;
   logic [NCNT_W-1:0] mean_fill_ff, mean_fill_in;
   logic [SUM_W-1:0]  mean_sum_ff, mean_sum_in;

   // word in flight
   logic                          acc_ff, acc_in;
   logic [SW-1:0]                 level_ff, level_in;
   logic [bamm_pkg::PCT_W-1:0]    pct_ff, pct_in;

   // held outputs
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_acc_ff, rsp_acc_in;
   logic [SW-1:0]                 last_level_ff, last_level_in;
   logic [bamm_pkg::PCT_W-1:0]    last_pct_ff, last_pct_in;
   logic                          stable_ff, stable_in;

   // configuration
   logic [SW-1:0] empty_ff, empty_in;
   logic [SW-1:0] full_ff, full_in;

   // shared divider
   logic [bamm_pkg::DIV_W-1:0]  div_quo_ff, div_quo_in;
   logic [bamm_pkg::DEN_W-1:0]  div_rem_ff, div_rem_in;
   logic [bamm_pkg::DEN_W-1:0]  div_den_ff, div_den_in;
   logic [bamm_pkg::DCNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [bamm_pkg::DEN_W:0]    div_trial, div_rem_step;
   logic                        div_ge;

   // combinational helpers
   logic              sample_ok;
   logic              req_fire;
   logic              rsp_load;
   logic [SW-1:0]     med_cand;
   logic [MCNT_W-1:0] lt_cnt, le_cnt, med_rank;
   logic              med_found;
   logic              mean_full;
   logic [SUM_W-1:0]  sum_new;
   logic [NCNT_W-1:0] fill_new;
   logic [SW:0]       num_diff, den_diff;
   logic [SW-1:0]     num_mag, den_mag;
   logic              pct_zero;
   logic [bamm_pkg::DIV_W-1:0] pct_prod;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign sample_ok    = (req_ch.sample > bamm_pkg::LOW_REJECT) &&
                         (req_ch.sample < bamm_pkg::HIGH_REJECT);

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.accepted       = rsp_acc_ff;
   assign rsp_ch.filtered_level = last_level_ff;
   assign rsp_ch.percent        = last_pct_ff;
   assign rsp_ch.stable         = stable_ff;

   // rank test of one median candidate against every filled entry
   always_comb begin
      lt_cnt   = '0;
      le_cnt   = '0;
      med_cand = median_win_ff[med_idx_ff];
      med_rank = (med_fill_ff - MCNT_W'(1)) >> 1;
      for (int j = 0; j < MEDIAN_WINDOW; j++) begin
         if (MCNT_W'(j) < med_fill_ff) begin
            if (median_win_ff[j] < med_cand) lt_cnt = lt_cnt + MCNT_W'(1);
            if (median_win_ff[j] <= med_cand) le_cnt = le_cnt + MCNT_W'(1);
         end
      end
      med_found = (lt_cnt <= med_rank) && (med_rank < le_cnt);
   end

   // running sum update
   assign mean_full = (mean_fill_ff == NCNT_W'(MEAN_WINDOW));
   assign sum_new   = mean_sum_ff + SUM_W'(med_val_ff) -
                      (mean_full ? SUM_W'(mean_win_ff[mean_pos_ff]) : SUM_W'(0));
   assign fill_new  = mean_full ? mean_fill_ff : mean_fill_ff + NCNT_W'(1);

   // percent operands: magnitudes and sign test
   assign num_diff = {1'b0, level_ff} - {1'b0, empty_ff};
   assign den_diff = {1'b0, full_ff} - {1'b0, empty_ff};
   assign num_mag  = num_diff[SW] ? SW'(-num_diff) : num_diff[SW-1:0];
   assign den_mag  = den_diff[SW] ? SW'(-den_diff) : den_diff[SW-1:0];
   assign pct_zero = (empty_ff == full_ff) || (num_mag == '0) ||
                     (num_diff[SW] != den_diff[SW]);
   assign pct_prod = bamm_pkg::DIV_W'(num_mag) * bamm_pkg::DIV_W'(bamm_pkg::PCT_FULL);

   // one restoring division step
   assign div_trial    = {div_rem_ff, div_quo_ff[bamm_pkg::DIV_W-1]};
   assign div_ge       = (div_trial >= {1'b0, div_den_ff});
   assign div_rem_step = div_ge ? div_trial - {1'b0, div_den_ff} : div_trial;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      med_we       = 1'b0;
      mean_we      = 1'b0;
      med_pos_in   = med_pos_ff;
      med_fill_in  = med_fill_ff;
      med_idx_in   = med_idx_ff;
      med_val_in   = med_val_ff;
      mean_pos_in  = mean_pos_ff;
      mean_fill_in = mean_fill_ff;
      mean_sum_in  = mean_sum_ff;
      acc_in       = acc_ff;
      level_in     = level_ff;
      pct_in       = pct_ff;
      div_quo_in   = div_quo_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_load     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               acc_in = sample_ok;
               if (sample_ok) begin
                  med_we     = 1'b1;
                  med_pos_in = (med_pos_ff == MIDX_W'(MEDIAN_WINDOW - 1)) ?
                               MIDX_W'(0) : med_pos_ff + MIDX_W'(1);
                  if (med_fill_ff != MCNT_W'(MEDIAN_WINDOW))
                     med_fill_in = med_fill_ff + MCNT_W'(1);
                  med_idx_in = '0;
                  state_in   = ST_MED;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MED: begin
            if (med_found) begin
               med_val_in = med_cand;
               state_in   = ST_SUM;
            end else begin
               med_idx_in = med_idx_ff + MIDX_W'(1);
            end
         end
         ST_SUM: begin
            mean_we      = 1'b1;
            mean_sum_in  = sum_new;
            mean_fill_in = fill_new;
            mean_pos_in  = (mean_pos_ff == NIDX_W'(MEAN_WINDOW - 1)) ?
                           NIDX_W'(0) : mean_pos_ff + NIDX_W'(1);
            div_quo_in   = bamm_pkg::DIV_W'(sum_new);
            div_rem_in   = '0;
            div_den_in   = bamm_pkg::DEN_W'(fill_new);
            div_cnt_in   = bamm_pkg::DCNT_W'(bamm_pkg::DIV_W);
            state_in     = ST_DIV_MEAN;
         end
         ST_DIV_MEAN, ST_DIV_PCT: begin
            if (div_cnt_ff != '0) begin
               div_quo_in = {div_quo_ff[bamm_pkg::DIV_W-2:0], div_ge};
               div_rem_in = div_rem_step[bamm_pkg::DEN_W-1:0];
               div_cnt_in = div_cnt_ff - bamm_pkg::DCNT_W'(1);
            end else if (state_ff == ST_DIV_MEAN) begin
               level_in = div_quo_ff[SW-1:0];
               state_in = ST_PCT;
            end else begin
               pct_in   = (div_quo_ff > bamm_pkg::DIV_W'(bamm_pkg::PCT_FULL)) ?
                          bamm_pkg::PCT_FULL : div_quo_ff[bamm_pkg::PCT_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_PCT: begin
            if (pct_zero) begin
               pct_in   = '0;
               state_in = ST_DONE;
            end else begin
               div_quo_in = pct_prod;
               div_rem_in = '0;
               div_den_in = bamm_pkg::DEN_W'(den_mag);
               div_cnt_in = bamm_pkg::DCNT_W'(bamm_pkg::DIV_W);
               state_in   = ST_DIV_PCT;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output word and held results
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_acc_in    = rsp_acc_ff;
      last_level_in = last_level_ff;
      last_pct_in   = last_pct_ff;
      stable_in     = stable_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_acc_in   = acc_ff;
         if (acc_ff) begin
            last_level_in = level_ff;
            last_pct_in   = pct_ff;
            stable_in     = 1'b1;
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // register writes
   always_comb begin
      empty_in = empty_ff;
      full_in  = full_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            bamm_pkg::REG_EMPTY_LEVEL: empty_in = csr_ch.data;
            bamm_pkg::REG_FULL_LEVEL:  full_in  = csr_ch.data;
            default: ;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         med_pos_ff    <= '0;
         med_fill_ff   <= '0;
         mean_pos_ff   <= '0;
         mean_fill_ff  <= '0;
         mean_sum_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         last_level_ff <= '0;
         last_pct_ff   <= '0;
         stable_ff     <= 1'b0;
         empty_ff      <= bamm_pkg::EMPTY_LEVEL_RST;
         full_ff       <= bamm_pkg::FULL_LEVEL_RST;
      end else begin
         state_ff      <= state_in;
         med_pos_ff    <= med_pos_in;
         med_fill_ff   <= med_fill_in;
         mean_pos_ff   <= mean_pos_in;
         mean_fill_ff  <= mean_fill_in;
         mean_sum_ff   <= mean_sum_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_level_ff <= last_level_in;
         last_pct_ff   <= last_pct_in;
         stable_ff     <= stable_in;
         empty_ff      <= empty_in;
         full_ff       <= full_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      med_idx_ff <= med_idx_in;
      med_val_ff <= med_val_in;
      acc_ff     <= acc_in;
      level_ff   <= level_in;
      pct_ff     <= pct_in;
      rsp_acc_ff <= rsp_acc_in;
      div_quo_ff <= div_quo_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      div_cnt_ff <= div_cnt_in;
   end

   // window stores
   always_ff @(posedge clock) begin
      if (med_we) median_win_ff[med_pos_ff] <= req_ch.sample;
      if (mean_we) mean_win_ff[mean_pos_ff] <= med_val_ff;
   end

endmodule

// ===== src/bamm_checker.sv =====
// bamm_checker: port-level assertions for the battery level filter, bound to the top level
// depends on bamm_pkg for field widths and the percent full scale

module bamm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_accepted,
   input logic [bamm_pkg::SAMPLE_W-1:0] rsp_filtered_level,
   input logic [bamm_pkg::PCT_W-1:0]    rsp_percent,
   input logic                          rsp_stable
);

   // percent never leaves its clamp range
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_percent <= bamm_pkg::PCT_FULL)
      else $error("percent above full scale");

   // an accepted sample always shows the stable flag
   a_acc_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_stable)
      else $error("accepted word without stable flag");

   // stable flag is sticky across words
   a_stable_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_stable |=> rsp_stable)
      else $error("stable flag dropped");

   // one word in flight: input closes right after a word is taken
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready while a word is in flight");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted) &&
      $stable(rsp_filtered_level) && $stable(rsp_percent) && $stable(rsp_stable))
      else $error("stalled result word changed");

endmodule

bind battery_adc_median_mean_percent bamm_checker u_bamm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_accepted       (rsp_ch.accepted),
   .rsp_filtered_level (rsp_ch.filtered_level),
   .rsp_percent        (rsp_ch.percent),
   .rsp_stable         (rsp_ch.stable)
);
